// File: hdl/fixed_point_point_rotator_defines.svh
// ----------------------------------------------------------------------------
// Point rotator assertion macros
// Clocked property checks shared by the rotator modules. Each expects clk_i
// and rst_ni to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_POINT_ROTATOR_DEFINES_SVH
`define FIXED_POINT_POINT_ROTATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Condition must hold at every edge outside reset
`define FPROT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent
`define FPROT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define FPROT_ASSERT(lbl, cond, msg)
`define FPROT_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/fprot_pkg.sv
// ----------------------------------------------------------------------------
// Point rotator package
// Widths, angle constants, the quarter-wave sine table and the beat payload
// that travels down the pipeline next to the angle.
// ----------------------------------------------------------------------------
package fprot_pkg;

  // Field widths
  localparam int COORD_W = 13;
  localparam int ANGLE_W = 16;
  localparam int OUT_W   = 16;
  localparam int DELTA_W = COORD_W + 1;
  localparam int TRIG_W  = 12;
  localparam int PROD_W  = DELTA_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int FRAC_BITS = 10;

  // Angle constants (degrees)
  localparam int DEG_QUARTER = 90;
  localparam int DEG_HALF    = 180;
  localparam int DEG_3Q      = 270;
  localparam int DEG_FULL    = 360;
  localparam int TRIG_PEAK   = 1040;

  // Offset that makes every angle non-negative, a whole multiple of 360;
  // biased angles span 352..65887 and need ANGLE_W+1 bits
  localparam int ANGLE_BIAS  = 33120;
  // floor(a / 360) == (a * RECIP_360) >> RECIP_SHIFT for a below 74000
  localparam int RECIP_360   = 46604;
  localparam int RECIP_SHIFT = 24;
  localparam int QUOT_W      = 8;
  localparam int REM_W       = 9;

  // Quarter-wave sine, 0..90 degrees, scaled by 1024 (peak kept at 1040)
  localparam logic [10:0] QUARTER_WAVE [0:90] = '{
    11'd0,    11'd18,   11'd36,   11'd54,   11'd71,   11'd89,   11'd107,  11'd125,
    11'd143,  11'd160,  11'd178,  11'd195,  11'd213,  11'd230,  11'd248,  11'd265,
    11'd282,  11'd299,  11'd316,  11'd333,  11'd350,  11'd367,  11'd384,  11'd400,
    11'd417,  11'd433,  11'd449,  11'd465,  11'd481,  11'd496,  11'd512,  11'd527,
    11'd543,  11'd558,  11'd573,  11'd587,  11'd602,  11'd616,  11'd630,  11'd644,
    11'd658,  11'd672,  11'd685,  11'd698,  11'd711,  11'd724,  11'd737,  11'd749,
    11'd761,  11'd773,  11'd784,  11'd796,  11'd807,  11'd818,  11'd828,  11'd839,
    11'd849,  11'd859,  11'd868,  11'd878,  11'd887,  11'd896,  11'd904,  11'd912,
    11'd920,  11'd928,  11'd935,  11'd943,  11'd950,  11'd957,  11'd964,  11'd970,
    11'd977,  11'd983,  11'd989,  11'd994,  11'd1000, 11'd1005, 11'd1010, 11'd1014,
    11'd1018, 11'd1022, 11'd1025, 11'd1028, 11'd1031, 11'd1033, 11'd1035, 11'd1037,
    11'd1038, 11'd1039, 11'd1040
  };

  // Geometry carried beside the angle: centre and offset of the point
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } geom_t;

  // Sine of an angle in 0..359 by quadrant folding
  function automatic logic signed [TRIG_W-1:0] sine_deg(input logic [REM_W-1:0] a);
    logic [6:0]               idx;
    logic                     neg;
    logic signed [TRIG_W-1:0] mag;
    if (a <= REM_W'(DEG_QUARTER)) begin
      idx = a[6:0];
      neg = 1'b0;
    end else if (a <= REM_W'(DEG_HALF)) begin
      idx = 7'(REM_W'(DEG_HALF) - a);
      neg = 1'b0;
    end else if (a <= REM_W'(DEG_3Q)) begin
      idx = 7'(a - REM_W'(DEG_HALF));
      neg = 1'b1;
    end else begin
      idx = 7'(REM_W'(DEG_FULL) - a);
      neg = 1'b1;
    end
    mag = signed'({1'b0, QUARTER_WAVE[idx]});
    return neg ? -mag : mag;
  endfunction

endpackage

// File: hdl/fixed_point_point_rotator.sv
// ----------------------------------------------------------------------------
// Fixed-point point rotator
// Rotates a point about a centre by a whole-degree angle using a
// quarter-wave sine table; five register stages, one beat per cycle when not stalled.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  input   | valid_i / stall_o  | center_x_i, center_y_i, point_x_i, point_y_i,
//          |                    | angle_deg_i
//  output  | valid_o / stall_i  | rotated_x_o, rotated_y_o
//
//  One beat in per cycle while stall_o is low.
//  Stages: angle times reciprocal, remainder, table lookup, products, sum.
//  Reset clears only the stage valid bits.
//  Each stage holds only while full and blocked below it, so bubbles close
//  up under stall and stall_o rises only when every stage is occupied.
// ----------------------------------------------------------------------------
`include "fixed_point_point_rotator_defines.svh"

module fixed_point_point_rotator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic signed [fprot_pkg::COORD_W-1:0] center_x_i,
  input  logic signed [fprot_pkg::COORD_W-1:0] center_y_i,
  input  logic signed [fprot_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [fprot_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [fprot_pkg::ANGLE_W-1:0] angle_deg_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic signed [fprot_pkg::OUT_W-1:0]   rotated_x_o,
  output logic signed [fprot_pkg::OUT_W-1:0]   rotated_y_o
);

  logic                                ang_valid, ang_stall;
  logic [fprot_pkg::REM_W-1:0]         ang_rem;
  fprot_pkg::geom_t                    ang_geom;
  logic                                trig_valid, trig_stall;
  logic signed [fprot_pkg::TRIG_W-1:0] trig_sin, trig_cos;
  fprot_pkg::geom_t                    trig_geom;

  // Angle reduction and offsets
  fprot_angle_reduce u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .angle_deg_i (angle_deg_i),
    .valid_o     (ang_valid),
    .stall_i     (ang_stall),
    .rem_o       (ang_rem),
    .geom_o      (ang_geom)
  );

  // Sine / cosine lookup
  fprot_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ang_valid),
    .stall_o (ang_stall),
    .rem_i   (ang_rem),
    .geom_i  (ang_geom),
    .valid_o (trig_valid),
    .stall_i (trig_stall),
    .sin_o   (trig_sin),
    .cos_o   (trig_cos),
    .geom_o  (trig_geom)
  );

  // Products and final sums
  fprot_rotate_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (trig_valid),
    .stall_o     (trig_stall),
    .sin_i       (trig_sin),
    .cos_i       (trig_cos),
    .geom_i      (trig_geom),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .rotated_x_o (rotated_x_o),
    .rotated_y_o (rotated_y_o)
  );

  `FPROT_ASSERT_IMP(a_stall_cause, stall_o, valid_o && stall_i,
    "input stalled while output not blocked")
  `FPROT_ASSERT_IMP(a_full_chain, stall_o, ang_valid && trig_valid,
    "input stalled with an empty stage")
  `FPROT_ASSERT_IMP(a_no_stall_idle, !valid_o, !stall_o && !trig_stall,
    "stall raised with empty output stage")

endmodule

// File: hdl/fprot_angle_reduce.sv
// ----------------------------------------------------------------------------
// Angle reduction
// Two stages: biased angle times reciprocal of 360, then remainder with one
// corrective subtract. Also forms the point offset from the centre.
// ----------------------------------------------------------------------------
`include "fixed_point_point_rotator_defines.svh"

module fprot_angle_reduce (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic signed [fprot_pkg::COORD_W-1:0]  center_x_i,
  input  logic signed [fprot_pkg::COORD_W-1:0]  center_y_i,
  input  logic signed [fprot_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [fprot_pkg::COORD_W-1:0]  point_y_i,
  input  logic signed [fprot_pkg::ANGLE_W-1:0]  angle_deg_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic [fprot_pkg::REM_W-1:0]           rem_o,
  output fprot_pkg::geom_t                      geom_o
);

  logic                              v1_q, v2_q;
  logic                              stall1, stall2;
  logic [fprot_pkg::ANGLE_W:0]       ang_sum;
  logic [fprot_pkg::ANGLE_W:0]       ang_off;
  logic [2*fprot_pkg::ANGLE_W:0]     recip_prod;
  logic [fprot_pkg::ANGLE_W:0]       ang_q;
  logic [fprot_pkg::QUOT_W-1:0]      quot_q;
  fprot_pkg::geom_t                  geom_d, geom1_q, geom2_q;
  logic [fprot_pkg::ANGLE_W:0]       quot_mul;
  logic [fprot_pkg::ANGLE_W:0]       rem_raw;
  logic [fprot_pkg::REM_W:0]         rem_wide;
  logic [fprot_pkg::REM_W-1:0]       rem_d, rem_q;

  // Stage stalls: a stage holds only when full and blocked downstream
  assign stall2  = v2_q & stall_i;
  assign stall1  = v1_q & stall2;
  assign stall_o = stall1;

  // Stage 1: bias angle non-negative, estimate quotient by 360
  assign ang_sum    = {angle_deg_i[fprot_pkg::ANGLE_W-1], angle_deg_i}
                    + (fprot_pkg::ANGLE_W+1)'(fprot_pkg::ANGLE_BIAS);
  assign ang_off    = ang_sum;
  assign recip_prod = (2*fprot_pkg::ANGLE_W+1)'(ang_off)
                    * (2*fprot_pkg::ANGLE_W+1)'(fprot_pkg::RECIP_360);

  always_comb begin
    geom_d.cx = center_x_i;
    geom_d.cy = center_y_i;
    geom_d.dx = fprot_pkg::DELTA_W'(point_x_i) - fprot_pkg::DELTA_W'(center_x_i);
    geom_d.dy = fprot_pkg::DELTA_W'(point_y_i) - fprot_pkg::DELTA_W'(center_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (!stall1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall1 && valid_i) begin
      ang_q   <= ang_off;
      quot_q  <= recip_prod[fprot_pkg::RECIP_SHIFT +: fprot_pkg::QUOT_W];
      geom1_q <= geom_d;
    end
  end

  // Stage 2: remainder, one correction if the estimate fell short
  assign quot_mul = (fprot_pkg::ANGLE_W+1)'(quot_q)
                  * (fprot_pkg::ANGLE_W+1)'(fprot_pkg::DEG_FULL);
  assign rem_raw  = ang_q - quot_mul;
  assign rem_wide = rem_raw[fprot_pkg::REM_W:0];

  always_comb begin
    if (rem_wide >= (fprot_pkg::REM_W+1)'(fprot_pkg::DEG_FULL)) begin
      rem_d = fprot_pkg::REM_W'(rem_wide - (fprot_pkg::REM_W+1)'(fprot_pkg::DEG_FULL));
    end else begin
      rem_d = rem_wide[fprot_pkg::REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (!stall2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall2 && v1_q) begin
      rem_q   <= rem_d;
      geom2_q <= geom1_q;
    end
  end

  assign valid_o = v2_q;
  assign rem_o   = rem_q;
  assign geom_o  = geom2_q;

  `FPROT_ASSERT_IMP(a_rem_range, v2_q, rem_q < fprot_pkg::REM_W'(fprot_pkg::DEG_FULL),
    "reduced angle out of range")
  `FPROT_ASSERT_IMP(a_quot_close, v1_q,
    (ang_q - quot_mul) < (fprot_pkg::ANGLE_W+1)'(2*fprot_pkg::DEG_FULL),
    "quotient estimate off by more than one")
  `FPROT_ASSERT_IMP(a_s1_hold, stall1, v2_q && stall_i, "stage 1 stalled without back pressure")

endmodule

// File: hdl/fprot_trig.sv
// ----------------------------------------------------------------------------
// Sine and cosine lookup
// One stage: folds the reduced angle and the angle plus 90 into the
// quarter-wave table and registers both values.
// ----------------------------------------------------------------------------
`include "fixed_point_point_rotator_defines.svh"

module fprot_trig (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic [fprot_pkg::REM_W-1:0]          rem_i,
  input  fprot_pkg::geom_t                     geom_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic signed [fprot_pkg::TRIG_W-1:0]  sin_o,
  output logic signed [fprot_pkg::TRIG_W-1:0]  cos_o,
  output fprot_pkg::geom_t                     geom_o
);

  logic                               v_q;
  logic                               stall;
  logic [fprot_pkg::REM_W:0]          cos_sum;
  logic [fprot_pkg::REM_W-1:0]        cos_ang;
  logic signed [fprot_pkg::TRIG_W-1:0] sin_q, cos_q;
  fprot_pkg::geom_t                   geom_q;

  assign stall   = v_q & stall_i;
  assign stall_o = stall;

  // Cosine angle: reduced angle plus 90, wrapped once
  assign cos_sum = (fprot_pkg::REM_W+1)'(rem_i) + (fprot_pkg::REM_W+1)'(fprot_pkg::DEG_QUARTER);

  always_comb begin
    if (cos_sum >= (fprot_pkg::REM_W+1)'(fprot_pkg::DEG_FULL)) begin
      cos_ang = fprot_pkg::REM_W'(cos_sum - (fprot_pkg::REM_W+1)'(fprot_pkg::DEG_FULL));
    end else begin
      cos_ang = cos_sum[fprot_pkg::REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!stall) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && valid_i) begin
      sin_q  <= fprot_pkg::sine_deg(rem_i);
      cos_q  <= fprot_pkg::sine_deg(cos_ang);
      geom_q <= geom_i;
    end
  end

  assign valid_o = v_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;
  assign geom_o  = geom_q;

  `FPROT_ASSERT_IMP(a_sin_bound, v_q,
    sin_q <= fprot_pkg::TRIG_W'(fprot_pkg::TRIG_PEAK)
    && sin_q >= -fprot_pkg::TRIG_W'(fprot_pkg::TRIG_PEAK), "sine beyond table peak")
  `FPROT_ASSERT_IMP(a_cos_bound, v_q,
    cos_q <= fprot_pkg::TRIG_W'(fprot_pkg::TRIG_PEAK)
    && cos_q >= -fprot_pkg::TRIG_W'(fprot_pkg::TRIG_PEAK), "cosine beyond table peak")
  `FPROT_ASSERT_IMP(a_in_angle, valid_i, rem_i < fprot_pkg::REM_W'(fprot_pkg::DEG_FULL),
    "unreduced angle at lookup")

endmodule

// File: hdl/fprot_rotate_mac.sv
// ----------------------------------------------------------------------------
// Rotation multiply-accumulate
// Two stages: four registered products, then the sums, floor shift by the
// fraction bits and the add of the centre into the output register.
// ----------------------------------------------------------------------------
`include "fixed_point_point_rotator_defines.svh"

module fprot_rotate_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic signed [fprot_pkg::TRIG_W-1:0]  sin_i,
  input  logic signed [fprot_pkg::TRIG_W-1:0]  cos_i,
  input  fprot_pkg::geom_t                     geom_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic signed [fprot_pkg::OUT_W-1:0]   rotated_x_o,
  output logic signed [fprot_pkg::OUT_W-1:0]   rotated_y_o
);

  logic                                v1_q, v2_q;
  logic                                stall1, stall2;
  logic signed [fprot_pkg::PROD_W-1:0] xc_q, ys_q, xs_q, yc_q;
  logic signed [fprot_pkg::COORD_W-1:0] cx_q, cy_q;
  logic signed [fprot_pkg::SUM_W-1:0]  sum_x, sum_y, sh_x, sh_y;
  logic signed [fprot_pkg::OUT_W-1:0]  rx_d, ry_d, rx_q, ry_q;

  assign stall2  = v2_q & stall_i;
  assign stall1  = v1_q & stall2;
  assign stall_o = stall1;

  // Stage 1: products of offsets with sine and cosine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (!stall1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall1 && valid_i) begin
      xc_q <= fprot_pkg::PROD_W'(geom_i.dx) * fprot_pkg::PROD_W'(cos_i);
      ys_q <= fprot_pkg::PROD_W'(geom_i.dy) * fprot_pkg::PROD_W'(sin_i);
      xs_q <= fprot_pkg::PROD_W'(geom_i.dx) * fprot_pkg::PROD_W'(sin_i);
      yc_q <= fprot_pkg::PROD_W'(geom_i.dy) * fprot_pkg::PROD_W'(cos_i);
      cx_q <= geom_i.cx;
      cy_q <= geom_i.cy;
    end
  end

  // Stage 2: combine, floor shift, add centre
  assign sum_x = fprot_pkg::SUM_W'(xc_q) - fprot_pkg::SUM_W'(ys_q);
  assign sum_y = fprot_pkg::SUM_W'(xs_q) + fprot_pkg::SUM_W'(yc_q);
  assign sh_x  = sum_x >>> fprot_pkg::FRAC_BITS;
  assign sh_y  = sum_y >>> fprot_pkg::FRAC_BITS;
  assign rx_d  = fprot_pkg::OUT_W'(fprot_pkg::SUM_W'(cx_q) + sh_x);
  assign ry_d  = fprot_pkg::OUT_W'(fprot_pkg::SUM_W'(cy_q) + sh_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (!stall2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall2 && v1_q) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
  end

  assign valid_o     = v2_q;
  assign rotated_x_o = rx_q;
  assign rotated_y_o = ry_q;

  `FPROT_ASSERT_IMP(a_s1_stall, stall1, v2_q && stall_i, "product stage held without cause")
  `FPROT_ASSERT_IMP(a_keep_full, $past(stall2), v2_q, "output beat dropped while stalled")
  `FPROT_ASSERT_IMP(a_advance, $past(v1_q && !stall2), v2_q, "product beat lost on advance")

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Point rotator testbench
// Sends rotation requests over the input channel and predicts each rotated
// point with a local fixed-point model. Every result beat is checked in order
// against the predicted one. Directed corner cases run first, then random
// beats under three idle mixes: sender idle, receiver idle, and back to back.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One request and one rotated point, at the port widths
  typedef struct packed {
    logic signed [fprot_pkg::COORD_W-1:0] center_x;
    logic signed [fprot_pkg::COORD_W-1:0] center_y;
    logic signed [fprot_pkg::COORD_W-1:0] point_x;
    logic signed [fprot_pkg::COORD_W-1:0] point_y;
    logic signed [fprot_pkg::ANGLE_W-1:0] angle_deg;
  } rotate_req_t;

  typedef struct packed {
    logic signed [fprot_pkg::OUT_W-1:0] rotated_x;
    logic signed [fprot_pkg::OUT_W-1:0] rotated_y;
  } rotate_res_t;

  localparam int LATENCY_CYCLES = 5;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int BEATS_PER_MIX  = 650;

  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 valid_i     = 1'b0;
  logic                                 stall_i     = 1'b0;
  logic signed [fprot_pkg::COORD_W-1:0] center_x_i  = '0;
  logic signed [fprot_pkg::COORD_W-1:0] center_y_i  = '0;
  logic signed [fprot_pkg::COORD_W-1:0] point_x_i   = '0;
  logic signed [fprot_pkg::COORD_W-1:0] point_y_i   = '0;
  logic signed [fprot_pkg::ANGLE_W-1:0] angle_deg_i = '0;
  logic                                 stall_o;
  logic                                 valid_o;
  logic signed [fprot_pkg::OUT_W-1:0]   rotated_x_o;
  logic signed [fprot_pkg::OUT_W-1:0]   rotated_y_o;

  rotate_res_t expected_rot_q[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;

  fixed_point_point_rotator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .angle_deg_i (angle_deg_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .rotated_x_o (rotated_x_o),
    .rotated_y_o (rotated_y_o)
  );

  // 8 ns clock
  always #4 clk_i = ~clk_i;

  // Sine of a reduced angle, folded onto the quarter-wave table
  function automatic int table_sine(input int a);
    if (a <= fprot_pkg::DEG_QUARTER) return int'(fprot_pkg::QUARTER_WAVE[a]);
    if (a <= fprot_pkg::DEG_HALF)
      return int'(fprot_pkg::QUARTER_WAVE[fprot_pkg::DEG_HALF - a]);
    if (a <= fprot_pkg::DEG_3Q)
      return -int'(fprot_pkg::QUARTER_WAVE[a - fprot_pkg::DEG_HALF]);
    return -int'(fprot_pkg::QUARTER_WAVE[fprot_pkg::DEG_FULL - a]);
  endfunction

  // Rotated point: center plus floor-shifted rotation of the offset
  function automatic rotate_res_t rotate_about_center(input rotate_req_t r);
    int          ang;
    int          s;
    int          c;
    longint      dx;
    longint      dy;
    longint      sum_x;
    longint      sum_y;
    rotate_res_t res;
    ang = int'(r.angle_deg) % fprot_pkg::DEG_FULL;
    if (ang < 0) ang += fprot_pkg::DEG_FULL;
    s = table_sine(ang);
    c = table_sine((ang + fprot_pkg::DEG_QUARTER) % fprot_pkg::DEG_FULL);
    dx = longint'(r.point_x) - longint'(r.center_x);
    dy = longint'(r.point_y) - longint'(r.center_y);
    sum_x = dx * c - dy * s;
    sum_y = dx * s + dy * c;
    res.rotated_x = fprot_pkg::OUT_W'(longint'(r.center_x)
                                      + (sum_x >>> fprot_pkg::FRAC_BITS));
    res.rotated_y = fprot_pkg::OUT_W'(longint'(r.center_y)
                                      + (sum_y >>> fprot_pkg::FRAC_BITS));
    return res;
  endfunction

  function automatic rotate_req_t make_req(input int cx, input int cy, input int px,
                                           input int py, input int ang);
    rotate_req_t r;
    r.center_x  = fprot_pkg::COORD_W'(cx);
    r.center_y  = fprot_pkg::COORD_W'(cy);
    r.point_x   = fprot_pkg::COORD_W'(px);
    r.point_y   = fprot_pkg::COORD_W'(py);
    r.angle_deg = fprot_pkg::ANGLE_W'(ang);
    return r;
  endfunction

  // Random request: full range, angles near quadrant edges, small or extreme
  // coordinates
  function automatic rotate_req_t random_point();
    rotate_req_t                          r;
    logic signed [fprot_pkg::COORD_W-1:0] ext [3];
    int                                   base;
    ext[0] = fprot_pkg::COORD_W'(-4096);
    ext[1] = '0;
    ext[2] = fprot_pkg::COORD_W'(4095);
    r.center_x  = fprot_pkg::COORD_W'($urandom);
    r.center_y  = fprot_pkg::COORD_W'($urandom);
    r.point_x   = fprot_pkg::COORD_W'($urandom);
    r.point_y   = fprot_pkg::COORD_W'($urandom);
    r.angle_deg = fprot_pkg::ANGLE_W'($urandom);
    case ($urandom_range(3))
      1: begin
        base = int'($urandom_range(3)) * fprot_pkg::DEG_QUARTER
             + int'($urandom_range(2)) - 1;
        r.angle_deg = fprot_pkg::ANGLE_W'(base
                      + (int'($urandom_range(180)) - 90) * fprot_pkg::DEG_FULL);
      end
      2: begin
        r.center_x = fprot_pkg::COORD_W'(int'($urandom_range(64)) - 32);
        r.center_y = fprot_pkg::COORD_W'(int'($urandom_range(64)) - 32);
        r.point_x  = fprot_pkg::COORD_W'(int'($urandom_range(64)) - 32);
        r.point_y  = fprot_pkg::COORD_W'(int'($urandom_range(64)) - 32);
      end
      3: begin
        r.center_x  = ext[$urandom_range(2)];
        r.center_y  = ext[$urandom_range(2)];
        r.point_x   = ext[$urandom_range(2)];
        r.point_y   = ext[$urandom_range(2)];
        r.angle_deg = fprot_pkg::ANGLE_W'(int'($urandom_range(719)) - fprot_pkg::DEG_FULL);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one beat: random idle cycles, then hold until accepted
  task automatic send_point(input rotate_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    center_x_i  <= r.center_x;
    center_y_i  <= r.center_y;
    point_x_i   <= r.point_x;
    point_y_i   <= r.point_y;
    angle_deg_i <= r.angle_deg;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    expected_rot_q.push_back(rotate_about_center(r));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    int waited;
    waited = 0;
    valid_i <= 1'b0;
    while (expected_rot_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_rot_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_rot_q.size());
      mismatch_count++;
      expected_rot_q.delete();
    end
  endtask

  task automatic send_random(input int count);
    repeat (count) send_point(random_point());
  endtask

  // Corner cases: quadrant edges, negative and extreme angles, extreme offsets
  task automatic test_directed();
    send_idle_pct = 19;
    recv_idle_pct = 49;
    send_point(make_req(0, 0, 0, 0, 0));
    send_point(make_req(0, 0, 4095, 4095, 0));
    send_point(make_req(0, 0, 4095, 4095, 90));
    send_point(make_req(0, 0, 4095, 4095, 180));
    send_point(make_req(0, 0, 4095, 4095, 270));
    send_point(make_req(0, 0, 4095, 4095, 359));
    send_point(make_req(0, 0, 4095, 4095, 360));
    send_point(make_req(0, 0, 4095, 4095, 91));
    send_point(make_req(0, 0, 4095, 4095, 181));
    send_point(make_req(0, 0, 4095, 4095, 271));
    send_point(make_req(0, 0, -4096, -4096, -1));
    send_point(make_req(0, 0, -4096, -4096, -90));
    send_point(make_req(0, 0, -4096, -4096, -360));
    send_point(make_req(0, 0, -4096, -4096, 32767));
    send_point(make_req(0, 0, -4096, -4096, -32768));
    // widest offsets in both directions
    send_point(make_req(-4096, 4095, 4095, -4096, 45));
    send_point(make_req(-4096, 4095, 4095, -4096, 135));
    send_point(make_req(4095, -4096, -4096, 4095, 225));
    send_point(make_req(4095, -4096, -4096, 4095, 315));
    send_point(make_req(-4096, -4096, 4095, 4095, 90));
    // point on the center
    send_point(make_req(1234, -777, 1234, -777, 33));
    // floor shift on small negative sums
    send_point(make_req(0, 0, 1, 0, 180));
    send_point(make_req(0, 0, 0, 1, 90));
    send_point(make_req(0, 0, -1, -1, 1));
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 19;
    recv_idle_pct = 49;
    send_random(BEATS_PER_MIX);
  endtask

  // Includes one full drain partway through
  task automatic test_random_receiver_idle();
    send_idle_pct = 49;
    recv_idle_pct = 19;
    send_random(BEATS_PER_MIX / 2);
    drain_results();
    send_random(BEATS_PER_MIX - BEATS_PER_MIX / 2);
  endtask

  task automatic test_random_back_to_back();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(BEATS_PER_MIX);
  endtask

  // Receiver stall
  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result beat checker
  always @(posedge clk_i) begin
    rotate_res_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_rot_q.size() == 0) begin
        $error("result beat with nothing expected: rotated_x %0d rotated_y %0d",
               rotated_x_o, rotated_y_o);
        mismatch_count++;
      end else begin
        want = expected_rot_q.pop_front();
        if (rotated_x_o !== want.rotated_x) begin
          $error("rotated_x: expected %0d, actual %0d", want.rotated_x, rotated_x_o);
          mismatch_count++;
        end
        if (rotated_y_o !== want.rotated_y) begin
          $error("rotated_y: expected %0d, actual %0d", want.rotated_y, rotated_y_o);
          mismatch_count++;
        end
      end
    end
  end

  // Test sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sender_idle();
    test_random_receiver_idle();
    test_random_back_to_back();
    drain_results();
    repeat (2 * LATENCY_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
